// ===== rtl/mafe_pkg.sv =====
`timescale 1ns / 1ps

package mafe_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] AllOnes  = 8'hFF;
  localparam logic [7:0] AddrReset = 8'h01;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       run_last;
    logic       frame_done;
  } out_item_t;

  // One classified PDU byte, as handed from the front to the back.
  typedef struct packed {
    logic       start;
    logic [7:0] addr;
    logic [7:0] pdu_byte;
    logic       last;
    logic [7:0] lrc;
  } mafe_cmd_t;

  typedef enum logic [3:0] {
    ST_COLON,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_BYTE_HI,
    ST_BYTE_LO,
    ST_LRC_HI,
    ST_LRC_LO,
    ST_CR,
    ST_LF
  } mafe_step_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'd0, nib};
    end else begin
      ch = ChUpperA + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/mafe_front.sv =====
`timescale 1ns / 1ps

module mafe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mafe_pkg::in_item_t  in_data,
  input  logic [7:0]          dev_addr,
  input  logic                q_full,
  output logic                q_push,
  output mafe_pkg::mafe_cmd_t q_wdata
);
  import mafe_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] lrc_r, lrc_nxt;
  logic [7:0] seed;
  logic [7:0] sum;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign seed = in_frame_r ? lrc_r : dev_addr;
  assign sum  = seed + in_data.pdu_byte;

  always_comb begin
    q_wdata.start    = !in_frame_r;
    q_wdata.addr     = dev_addr;
    q_wdata.pdu_byte = in_data.pdu_byte;
    q_wdata.last     = in_data.frame_end;
    q_wdata.lrc      = (sum ^ AllOnes) + 8'd1;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    lrc_nxt      = lrc_r;
    if (q_push) begin
      in_frame_nxt = !in_data.frame_end;
      lrc_nxt      = in_data.frame_end ? 8'd0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      lrc_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      lrc_r      <= lrc_nxt;
    end
  end

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_data.frame_end |=> !in_frame_r && lrc_r == 8'd0)
    else $error("frame state not cleared after last byte");

  a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_wdata.start == !in_frame_r)
    else $error("start flag mismatch");

  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !in_data.frame_end |=> in_frame_r)
    else $error("frame not open after middle byte");

endmodule

// ===== rtl/mafe_queue.sv =====
`timescale 1ns / 1ps

module mafe_queue #(
  parameter int unsigned DEPTH = mafe_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mafe_pkg::mafe_cmd_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output mafe_pkg::mafe_cmd_t rdata
);
  import mafe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mafe_cmd_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/mafe_back.sv =====
`timescale 1ns / 1ps

module mafe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  mafe_pkg::mafe_cmd_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mafe_pkg::out_item_t out_data
);
  import mafe_pkg::*;

  mafe_step_t step_r, step_nxt;
  mafe_step_t step;
  mafe_step_t end_step;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic       emit;
  logic [7:0] ch;

  assign load     = !out_valid_r || out_ready;
  assign emit     = q_not_empty && load;
  assign step     = first_r ? (q_rdata.start ? ST_COLON : ST_BYTE_HI) : step_r;
  assign end_step = q_rdata.last ? ST_LF : ST_BYTE_LO;
  assign q_pop    = emit && (step == end_step);

  always_comb begin
    unique case (step)
      ST_COLON:   ch = ChColon;
      ST_ADDR_HI: ch = hex_digit(q_rdata.addr[7:4]);
      ST_ADDR_LO: ch = hex_digit(q_rdata.addr[3:0]);
      ST_BYTE_HI: ch = hex_digit(q_rdata.pdu_byte[7:4]);
      ST_BYTE_LO: ch = hex_digit(q_rdata.pdu_byte[3:0]);
      ST_LRC_HI:  ch = hex_digit(q_rdata.lrc[7:4]);
      ST_LRC_LO:  ch = hex_digit(q_rdata.lrc[3:0]);
      ST_CR:      ch = ChCr;
      ST_LF:      ch = ChLf;
      default:    ch = ChLf;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.ascii_char = ch;
      out_data_nxt.run_last   = (step == end_step);
      out_data_nxt.frame_done = (step == ST_LF);
      if (step == end_step) begin
        first_nxt = 1'b1;
      end else begin
        first_nxt = 1'b0;
        // advance through the fixed character order
        unique case (step)
          ST_COLON:   step_nxt = ST_ADDR_HI;
          ST_ADDR_HI: step_nxt = ST_ADDR_LO;
          ST_ADDR_LO: step_nxt = ST_BYTE_HI;
          ST_BYTE_HI: step_nxt = ST_BYTE_LO;
          ST_BYTE_LO: step_nxt = ST_LRC_HI;
          ST_LRC_HI:  step_nxt = ST_LRC_LO;
          ST_LRC_LO:  step_nxt = ST_CR;
          ST_CR:      step_nxt = ST_LF;
          ST_LF:      step_nxt = ST_COLON;
          default:    step_nxt = ST_COLON;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_COLON;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_done |->
      out_data_r.run_last && out_data_r.ascii_char == ChLf)
    else $error("frame_done not on closing LF");

  a_colon_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && step == ST_COLON |=> !first_r)
    else $error("header ended a command early");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> first_r && out_valid_r && out_data_r.run_last)
    else $error("pop without final character");

endmodule

// ===== rtl/modbus_ascii_frame_encoder_unit.sv =====
`timescale 1ns / 1ps

// Modbus ASCII frame encoder with LRC.
// Input channel (in_valid/in_ready/in_data): one response PDU byte per
// transfer, frame_end set on the last byte of a frame.
// Output channel (out_valid/out_ready/out_data): one frame character per
// transfer; run_last marks the last character caused by an input byte,
// frame_done marks the closing LF.
// Config channel (cfg_valid/cfg_ready/cfg_data): slave address, always ready;
// it is sampled when the first byte of a frame is accepted.
// Each byte passes through the command queue, then its first character is
// registered in the output stage, which emits one character per cycle while
// the receiver is ready. A middle byte yields its two hex digits; a first
// byte adds the colon and address digits, a last byte the LRC digits, CR, LF.
// A small command queue lets input transfers go on while the sequencer works.
// Reset: address returns to 1, the LRC clears, the queue empties and the next
// byte starts a new frame.
// When the receiver stalls, the output holds its character; the queue then
// fills and in_ready drops until characters drain.
module modbus_ascii_frame_encoder_unit #(
  parameter int unsigned QDEPTH = mafe_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mafe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mafe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import mafe_pkg::*;

  logic [7:0] addr_r, addr_nxt;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  mafe_cmd_t  q_wdata;
  mafe_cmd_t  q_rdata;

  assign cfg_ready = 1'b1;
  assign addr_nxt  = (cfg_valid && cfg_ready) ? cfg_data : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= AddrReset;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  mafe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dev_addr (addr_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mafe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  mafe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sim/tb_modbus_ascii_frame_encoder_unit.sv =====
`timescale 1ns / 1ps

module tb_modbus_ascii_frame_encoder_unit;
  import mafe_pkg::*;

  localparam logic [127:0] HexDigits = "0123456789ABCDEF";
  localparam int MaxChars = 9;
  localparam int ReportLimit = 10;
  localparam int HoldCycles = 80;

  typedef struct {
    logic        set_addr;
    logic [7:0]  addr;
    logic [7:0]  pdu_byte;
    logic        frame_end;
    int          typed_len;
    logic [71:0] typed_text;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // Encoder shadow state
  logic [7:0] enc_addr = AddrReset;
  logic [7:0] enc_lrc = 8'h00;
  logic       enc_open = 1'b0;
  out_item_t  pred_chars [MaxChars];
  int         pred_n;

  out_item_t  frame_chars_q [$];
  dir_row_t   dir_rows [$];

  int typed_len = 0;
  logic [71:0] typed_text = '0;
  int snd_idle_pct = 35;
  int rcv_idle_pct = 66;
  int hold_req = 0;
  int hold_left = 0;
  int n_sent = 0;
  int err_count = 0;

  always #4 clk = ~clk;

  modbus_ascii_frame_encoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic out_item_t mk_char(input logic [7:0] ch, input logic done);
    out_item_t c;
    c.ascii_char = ch;
    c.run_last   = 1'b0;
    c.frame_done = done;
    return c;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    return HexDigits[8 * (15 - nib) +: 8];
  endfunction

  task automatic predict_pdu_chars(input in_item_t it);
    logic [7:0] lrc;
    pred_n = 0;
    if (!enc_open) begin
      pred_chars[pred_n] = mk_char(ChColon, 1'b0);             pred_n++;
      pred_chars[pred_n] = mk_char(nibble_char(enc_addr[7:4]), 1'b0); pred_n++;
      pred_chars[pred_n] = mk_char(nibble_char(enc_addr[3:0]), 1'b0); pred_n++;
      enc_lrc  = enc_addr;
      enc_open = 1'b1;
    end
    pred_chars[pred_n] = mk_char(nibble_char(it.pdu_byte[7:4]), 1'b0); pred_n++;
    pred_chars[pred_n] = mk_char(nibble_char(it.pdu_byte[3:0]), 1'b0); pred_n++;
    enc_lrc = enc_lrc + it.pdu_byte;
    if (it.frame_end) begin
      lrc = ~enc_lrc + 8'd1;
      pred_chars[pred_n] = mk_char(nibble_char(lrc[7:4]), 1'b0); pred_n++;
      pred_chars[pred_n] = mk_char(nibble_char(lrc[3:0]), 1'b0); pred_n++;
      pred_chars[pred_n] = mk_char(ChCr, 1'b0);                  pred_n++;
      pred_chars[pred_n] = mk_char(ChLf, 1'b1);                  pred_n++;
      enc_open = 1'b0;
      enc_lrc  = 8'h00;
    end
    pred_chars[pred_n - 1].run_last = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t exp_c;
    out_item_t got_c;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        enc_addr = cfg_data;
      end
      if (in_valid && in_ready) begin
        // Advance the shadow state even when the row carries a typed frame
        predict_pdu_chars(in_data);
        if (typed_len != 0) begin
          for (int i = 0; i < typed_len; i++) begin
            exp_c = mk_char(typed_text[8 * (typed_len - 1 - i) +: 8],
                            (i == typed_len - 1) && in_data.frame_end);
            exp_c.run_last = (i == typed_len - 1);
            frame_chars_q.push_back(exp_c);
          end
        end else begin
          for (int i = 0; i < pred_n; i++) begin
            frame_chars_q.push_back(pred_chars[i]);
          end
        end
      end
      if (out_valid && out_ready) begin
        got_c = out_data;
        if (frame_chars_q.size() == 0) begin
          err_count++;
          if (err_count <= ReportLimit) begin
            $display("ERROR: unexpected char %h run_last %b frame_done %b at %0t",
                     got_c.ascii_char, got_c.run_last, got_c.frame_done, $realtime);
          end
        end else begin
          exp_c = frame_chars_q.pop_front();
          if (got_c.ascii_char !== exp_c.ascii_char || got_c.run_last !== exp_c.run_last ||
              got_c.frame_done !== exp_c.frame_done) begin
            err_count++;
            if (err_count <= ReportLimit) begin
              $display("ERROR: char exp %h/%b/%b got %h/%b/%b at %0t",
                       exp_c.ascii_char, exp_c.run_last, exp_c.frame_done,
                       got_c.ascii_char, got_c.run_last, got_c.frame_done, $realtime);
            end
          end
        end
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, e};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
  endtask

  // Drop valid and wait until every expected char has come out
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (frame_chars_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_addr(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input logic set_addr, input logic [7:0] addr,
                                  input logic [7:0] b, input logic e,
                                  input int tlen, input logic [71:0] ttext);
    dir_row_t r;
    r.set_addr   = set_addr;
    r.addr       = addr;
    r.pdu_byte   = b;
    r.frame_end  = e;
    r.typed_len  = tlen;
    r.typed_text = ttext;
    dir_rows.push_back(r);
  endfunction

  task automatic run_random_phase(input int snd_pct, input int rcv_pct, input int n_items,
                                  input logic [7:0] first_addr, input logic with_hold);
    int goal;
    int len;
    logic held;
    drain_frames();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_addr(first_addr);
    goal = n_sent + n_items;
    held = 1'b0;
    while (n_sent < goal) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      if (with_hold && !held && n_sent >= goal - n_items / 2) begin
        hold_req = HoldCycles;
        held = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        offer_byte(8'($urandom_range(255)), k == len - 1);
        // Occasionally change the address, sometimes inside an open frame
        if ($urandom_range(19) == 0) begin
          drain_frames();
          write_addr(8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    add_row(1'b0, 8'h00, 8'h00, 1'b1, 9, {":0100FF", ChCr, ChLf});
    add_row(1'b1, 8'hFF, 8'hFF, 1'b1, 9, {":FFFF02", ChCr, ChLf});
    add_row(1'b1, 8'h00, 8'h00, 1'b1, 9, {":000000", ChCr, ChLf});
    add_row(1'b1, 8'h5A, 8'h00, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'hFF, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h80, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h7F, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h01, 1'b1, 0, '0);
    // Address written inside an open frame applies to the next frame only
    add_row(1'b1, 8'h11, 8'h3C, 1'b0, 0, '0);
    add_row(1'b1, 8'h22, 8'hA5, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h0F, 1'b1, 0, '0);
    add_row(1'b0, 8'h00, 8'h9E, 1'b1, 0, '0);
    add_row(1'b0, 8'h00, 8'h12, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h34, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h56, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h78, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'h9A, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'hBC, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'hDE, 1'b0, 0, '0);
    add_row(1'b0, 8'h00, 8'hF0, 1'b1, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_addr) begin
        drain_frames();
        write_addr(dir_rows[i].addr);
      end
      typed_len  = dir_rows[i].typed_len;
      typed_text = dir_rows[i].typed_text;
      offer_byte(dir_rows[i].pdu_byte, dir_rows[i].frame_end);
    end
    typed_len = 0;

    run_random_phase(35, 66, 95, 8'h00, 1'b0);
    run_random_phase(66, 35, 95, 8'hFF, 1'b0);
    run_random_phase(0, 0, 95, 8'($urandom_range(255)), 1'b1);

    drain_frames();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== modbus_ascii_frame_encoder_unit.f =====
rtl/mafe_pkg.sv
rtl/mafe_front.sv
rtl/mafe_queue.sv
rtl/mafe_back.sv
rtl/modbus_ascii_frame_encoder_unit.sv
sim/tb_modbus_ascii_frame_encoder_unit.sv
